FILE: hdl/dma_prd_descriptor_builder_assert.svh
// ----------------------------------------------------------------------------
// DMA PRD descriptor builder assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DMA_PRD_DESCRIPTOR_BUILDER_ASSERT_SVH
`define DMA_PRD_DESCRIPTOR_BUILDER_ASSERT_SVH

// Same-cycle implication.
`define DPDB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DPDB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/dpdb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMA PRD descriptor builder package
// Shared constants and the entry and bundle types passed from front to back.
// ----------------------------------------------------------------------------
package dpdb_pkg;

  localparam int unsigned TableCapacityDefault = 256;
  localparam int unsigned MaxResults           = 3;
  localparam int unsigned QueueDepthDefault    = 2;
  localparam int unsigned SlotIdxW             = $clog2(MaxResults);

  // One 64 KiB window, in 17 bits.
  localparam logic [16:0] WinBytes = 17'h10000;

  typedef struct packed {
    logic [31:0] address;
    logic [15:0] count;
    logic        eot;
    logic        overflow;
  } entry_t;

  // All results caused by one request, in order; last_idx is the index of
  // the final valid slot.
  typedef struct packed {
    logic [SlotIdxW-1:0]           last_idx;
    entry_t [MaxResults-1:0]       slot;
  } bundle_t;

endpackage

FILE: hdl/dpdb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMA PRD descriptor builder front end
// Holds the open run, merges and splits each segment, and forms the bundle
// of results that the request causes.
// ----------------------------------------------------------------------------
module dpdb_front
  import dpdb_pkg::*;
#(
  parameter int unsigned TableCapacity = TableCapacityDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [31:0] segment_address_i,
  input  logic [16:0] segment_length_i,
  input  logic        final_segment_i,
  output logic        push_o,
  output bundle_t     bundle_o
);

  localparam int unsigned CntW  = $clog2(TableCapacity + 1);
  localparam int unsigned NCand = 5;

  logic [31:0]     pend_start_q, pend_start_d;
  logic [16:0]     pend_bytes_q, pend_bytes_d;
  logic            pend_q, pend_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovfl_q, ovfl_d;

  logic [16:0]     len_sat, room, room_new, lim_a, take_a, rem_a, a_bytes;
  logic [31:0]     run_end, addr_b, a_start;
  logic            len_nz, merge, new_a, has_b, ovf_a, ovf_b, act;
  logic [CntW-1:0] cnt_a;
  logic [31:0]     fin_start;
  logic [16:0]     fin_bytes;
  logic            fin_pend;
  entry_t          cand [NCand];
  logic [NCand-1:0] en;
  logic [SlotIdxW:0] k;

  always_comb begin
    act      = !ovfl_q;
    len_sat  = (segment_length_i > WinBytes) ? WinBytes : segment_length_i;
    len_nz   = (len_sat != '0);
    run_end  = pend_start_q + 32'(pend_bytes_q);
    room     = pend_q ? (WinBytes - 17'(pend_start_q[15:0]) - pend_bytes_q) : '0;
    merge    = len_nz && pend_q && (segment_address_i == run_end) && (room != '0);
    new_a    = len_nz && !merge;
    room_new = WinBytes - 17'(segment_address_i[15:0]);
    lim_a    = merge ? room : room_new;
    take_a   = (len_sat < lim_a) ? len_sat : lim_a;
    rem_a    = len_sat - take_a;
    has_b    = (rem_a != '0);
    addr_b   = segment_address_i + 32'(take_a);
    a_start  = merge ? pend_start_q : segment_address_i;
    a_bytes  = merge ? (pend_bytes_q + take_a) : take_a;
    cnt_a    = cnt_q + CntW'(new_a);
    ovf_a    = act && new_a && (cnt_q >= CntW'(TableCapacity));
    ovf_b    = act && !ovf_a && has_b && (cnt_a >= CntW'(TableCapacity));

    if (has_b) begin
      fin_start = addr_b;
      fin_bytes = rem_a;
      fin_pend  = 1'b1;
    end else if (len_nz) begin
      fin_start = a_start;
      fin_bytes = a_bytes;
      fin_pend  = 1'b1;
    end else begin
      fin_start = pend_start_q;
      fin_bytes = pend_bytes_q;
      fin_pend  = pend_q;
    end

    // Candidate results in emission order.
    cand[0] = '{address: pend_start_q, count: pend_bytes_q[15:0], eot: 1'b0,
                overflow: 1'b0};
    cand[1] = '{address: '0, count: '0, eot: 1'b0, overflow: 1'b1};
    cand[2] = '{address: a_start, count: a_bytes[15:0], eot: 1'b0, overflow: 1'b0};
    cand[3] = '{address: '0, count: '0, eot: 1'b0, overflow: 1'b1};
    cand[4] = '{address: fin_start, count: fin_bytes[15:0], eot: 1'b1,
                overflow: 1'b0};
    en[0] = act && new_a && pend_q;
    en[1] = ovf_a;
    en[2] = act && !ovf_a && has_b;
    en[3] = ovf_b;
    en[4] = act && !ovf_a && !ovf_b && final_segment_i && fin_pend;

    // Pack the enabled candidates into consecutive slots.
    bundle_o = '0;
    k        = '0;
    for (int i = 0; i < NCand; i++) begin
      if (en[i] && (k < (SlotIdxW + 1)'(MaxResults))) begin
        bundle_o.slot[k[SlotIdxW-1:0]] = cand[i];
        k = k + 1'b1;
      end
    end
    bundle_o.last_idx = SlotIdxW'(k - 1'b1);
    push_o = accept_i && (k != '0);

    pend_start_d = pend_start_q;
    pend_bytes_d = pend_bytes_q;
    pend_d       = pend_q;
    cnt_d        = cnt_q;
    ovfl_d       = ovfl_q;
    if (accept_i) begin
      if (ovfl_q || ovf_a || ovf_b || final_segment_i) begin
        pend_start_d = '0;
        pend_bytes_d = '0;
        pend_d       = 1'b0;
        cnt_d        = '0;
        ovfl_d       = (ovfl_q || ovf_a || ovf_b) && !final_segment_i;
      end else begin
        pend_start_d = fin_start;
        pend_bytes_d = fin_bytes;
        pend_d       = fin_pend;
        cnt_d        = cnt_a + CntW'(has_b);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_start_q <= '0;
      pend_bytes_q <= '0;
      pend_q       <= 1'b0;
      cnt_q        <= '0;
      ovfl_q       <= 1'b0;
    end else begin
      pend_start_q <= pend_start_d;
      pend_bytes_q <= pend_bytes_d;
      pend_q       <= pend_d;
      cnt_q        <= cnt_d;
      ovfl_q       <= ovfl_d;
    end
  end

  `include "dma_prd_descriptor_builder_assert.svh"

  `DPDB_ASSERT_NOW(a_run_in_window, pend_q, (18'(pend_start_q[15:0]) + 18'(pend_bytes_q) <= 18'h10000), "open run crosses a 64 KiB boundary")
  `DPDB_ASSERT_NOW(a_cnt_bounded, 1'b1, (cnt_q <= CntW'(TableCapacity)), "entry count above capacity")
  `DPDB_ASSERT_NOW(a_ovfl_no_run, ovfl_q, (!pend_q && (cnt_q == '0)), "run held while dropping")

endmodule

FILE: hdl/dpdb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMA PRD descriptor builder result queue
// Short FIFO of result bundles between the front end and the back end.
// ----------------------------------------------------------------------------
module dpdb_queue
  import dpdb_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  input  logic    pop_i,
  output logic    full_o,
  output logic    head_valid_o,
  output bundle_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FillW = $clog2(Depth + 1);

  bundle_t          store_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;

  always_comb begin
    full_o       = (fill_q == FillW'(Depth));
    head_valid_o = (fill_q != '0);
    head_o       = store_q[rd_ptr_q];
    wr_ptr_d     = wr_ptr_q;
    rd_ptr_d     = rd_ptr_q;
    fill_d       = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  `include "dma_prd_descriptor_builder_assert.svh"

  `DPDB_ASSERT_NOW(a_no_push_full, push_i, (!full_o || pop_i), "push into a full queue")
  `DPDB_ASSERT_NOW(a_no_pop_empty, pop_i, head_valid_o, "pop from an empty queue")
  `DPDB_ASSERT_NEXT(a_push_shows, (push_i && !pop_i), head_valid_o, "pushed bundle not visible")

endmodule

FILE: hdl/dpdb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMA PRD descriptor builder back end
// Walks the head bundle one result per unstalled cycle into the output register.
// ----------------------------------------------------------------------------
module dpdb_back
  import dpdb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  bundle_t     head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] entry_address_o,
  output logic [15:0] entry_count_o,
  output logic        end_of_table_o,
  output logic        table_overflow_o,
  output logic        run_last_o
);

  logic [SlotIdxW-1:0] idx_q, idx_d;
  logic                valid_q, valid_d;
  entry_t              res_q, res_d;
  logic                last_q, last_d;
  logic                load, at_last;
  entry_t              cur;

  always_comb begin
    case (idx_q)
      2'd1:    cur = head_i.slot[1];
      2'd2:    cur = head_i.slot[2];
      default: cur = head_i.slot[0];
    endcase
    at_last = (idx_q == head_i.last_idx);
    load    = head_valid_i && (!valid_q || !out_stall_i);
    pop_o   = load && at_last;
    idx_d   = idx_q;
    res_d   = res_q;
    last_d  = last_q;
    valid_d = valid_q && out_stall_i;
    if (load) begin
      valid_d = 1'b1;
      res_d   = cur;
      last_d  = at_last;
      idx_d   = at_last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    last_q <= last_d;
  end

  assign out_valid_o      = valid_q;
  assign entry_address_o  = res_q.address;
  assign entry_count_o    = res_q.count;
  assign end_of_table_o   = res_q.eot;
  assign table_overflow_o = res_q.overflow;
  assign run_last_o       = last_q;

  `include "dma_prd_descriptor_builder_assert.svh"

  `DPDB_ASSERT_NOW(a_idx_in_bundle, head_valid_i, (idx_q <= head_i.last_idx), "slot index past end of bundle")
  `DPDB_ASSERT_NOW(a_idx_needs_head, (idx_q != '0), head_valid_i, "mid-bundle without a head")
  `DPDB_ASSERT_NOW(a_ovf_empty, (valid_q && res_q.overflow), ((res_q.address == '0) && (res_q.count == '0) && !res_q.eot && last_q), "error result carries an entry")

endmodule

FILE: hdl/dma_prd_descriptor_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMA PRD descriptor builder
// Turns buffer segments into bus-master descriptor table entries.
// ----------------------------------------------------------------------------
//
//   Channel  | Handshake              | Moves
//   ---------+------------------------+----------------------------------------
//   in       | in_valid_i / in_stall_o | one segment request: address, length,
//            |                        | final flag
//   out      | out_valid_o / out_stall_i | one result: entry or error, with
//            |                        | the last-of-request mark
//
// A request is taken whenever the result queue has room, so requests can
// follow each other back to back. Each request causes zero to three
// results, and the back end hands out one result per cycle while the output
// is not stalled, from a single output register. The results of a request
// pass through the queue and then the output register before they are on
// the output.
// Reset is asynchronous and clears the open run, the entry count, the drop
// state, the queue pointers and the output valid flag; there is no clearing
// pass. A stall on the output fills the two-bundle queue and only then stalls
// the input; a request causing no result still waits for a free queue slot.
//
// The front end holds the open run (start, length) and the per-table entry
// count. A nonempty segment that begins exactly at the run end and finds
// room below the next 64 KiB boundary is merged; otherwise the run is closed
// and a new one opened. A segment can be cut once more at a boundary, so it
// yields at most two run pieces. When the next entry would pass the table
// capacity, the entries already due are emitted, then a single error result,
// and the rest of the table is dropped up to the final segment.
// ----------------------------------------------------------------------------
module dma_prd_descriptor_builder
  import dpdb_pkg::*;
#(
  parameter int unsigned TableCapacity = TableCapacityDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] segment_address_i,
  input  logic [16:0] segment_length_i,
  input  logic        final_segment_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] entry_address_o,
  output logic [15:0] entry_count_o,
  output logic        end_of_table_o,
  output logic        table_overflow_o,
  output logic        run_last_o
);

  logic    accept;
  logic    push, pop, full, head_valid;
  bundle_t push_bundle, head_bundle;

  // The input stalls only on a full queue.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  dpdb_front #(
    .TableCapacity(TableCapacity)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .segment_address_i (segment_address_i),
    .segment_length_i  (segment_length_i),
    .final_segment_i   (final_segment_i),
    .push_o            (push),
    .bundle_o          (push_bundle)
  );

  dpdb_queue #(
    .Depth(QueueDepthDefault)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_bundle),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head_bundle)
  );

  dpdb_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_i           (head_bundle),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .entry_address_o  (entry_address_o),
    .entry_count_o    (entry_count_o),
    .end_of_table_o   (end_of_table_o),
    .table_overflow_o (table_overflow_o),
    .run_last_o       (run_last_o)
  );

endmodule

FILE: test/dma_prd_descriptor_builder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMA PRD descriptor builder testbench
// Drives buffer segments into the builder under several idle and stall
// patterns. It predicts the descriptor entries and overflow errors in a
// scoreboard and compares every result leaving the block with the prediction.
// ----------------------------------------------------------------------------
module dma_prd_descriptor_builder_test;
  import dpdb_pkg::*;

  localparam int unsigned Capacity   = TableCapacityDefault;
  localparam int unsigned IdleLimit  = 5000;  // cycles without any handshake
  localparam int unsigned HoldCycles = 300;   // long output hold-off
  localparam int unsigned MaxShown   = 10;

  // One expected or observed result of the builder.
  typedef struct packed {
    logic [31:0] address;
    logic [15:0] count;
    logic        eot;
    logic        overflow;
    logic        run_last;
  } prd_result_t;

  // The scoreboard keeps its own copy of the builder state: the open run of
  // bytes, the number of entries created in the current table and whether
  // the current table has overflowed and is being dropped.
  class prd_scoreboard;
    logic [31:0] run_start;
    logic [16:0] run_bytes;
    bit          run_open;
    int unsigned entry_total;
    bit          dropping;
    prd_result_t expected_q[$];
    int unsigned errors;

    function void clear_run();
      run_start   = '0;
      run_bytes   = '0;
      run_open    = 1'b0;
      entry_total = 0;
      dropping    = 1'b0;
    endfunction

    function prd_result_t make_entry(logic [31:0] address, logic [16:0] bytes, logic eot);
      prd_result_t r;
      r          = '0;
      r.address  = address;
      r.count    = bytes[15:0];
      r.eot      = eot;
      return r;
    endfunction

    // Works out the results caused by one accepted segment request.
    function void note_segment(logic [31:0] seg_addr, logic [16:0] seg_len, logic seg_final);
      prd_result_t due[$];
      prd_result_t err;
      logic [31:0] a;
      logic [31:0] remaining;
      logic [31:0] room;
      logic [31:0] take;
      logic [31:0] run_end;
      bit          stop;
      a         = seg_addr;
      remaining = (seg_len > WinBytes) ? 32'(WinBytes) : 32'(seg_len);
      stop      = 1'b0;
      err       = '0;
      err.overflow = 1'b1;
      if (dropping) begin
        // The rest of an overflowed table is dropped; its final segment
        // closes it.
        if (seg_final) clear_run();
        stop = 1'b1;
      end
      while (remaining != 0 && !stop) begin
        run_end = run_start + run_bytes;
        room    = run_open ? (32'h10000 - run_start[15:0] - run_bytes) : 32'h0;
        if (run_open && a == run_end && room != 0) begin
          take      = (remaining < room) ? remaining : room;
          run_bytes = run_bytes + take[16:0];
        end else begin
          if (run_open) begin
            due.push_back(make_entry(run_start, run_bytes, 1'b0));
            run_open = 1'b0;
          end
          if (entry_total >= Capacity) begin
            due.push_back(err);
            clear_run();
            dropping = !seg_final;
            stop     = 1'b1;
          end else begin
            entry_total++;
            room      = 32'h10000 - a[15:0];
            take      = (remaining < room) ? remaining : room;
            run_start = a;
            run_bytes = take[16:0];
            run_open  = 1'b1;
          end
        end
        if (!stop) begin
          a         = a + take;
          remaining = remaining - take;
        end
      end
      if (seg_final && !stop) begin
        if (run_open) due.push_back(make_entry(run_start, run_bytes, 1'b1));
        clear_run();
      end
      if (due.size() != 0) due[due.size() - 1].run_last = 1'b1;
      foreach (due[i]) expected_q.push_back(due[i]);
    endfunction

    function void flag(string what, prd_result_t want, prd_result_t got);
      errors++;
      if (errors <= MaxShown)
        $display("%0t %s: expected addr=%h count=%h eot=%b ovf=%b last=%b, got addr=%h count=%h eot=%b ovf=%b last=%b",
                 $time, what, want.address, want.count, want.eot, want.overflow,
                 want.run_last, got.address, got.count, got.eot, got.overflow,
                 got.run_last);
    endfunction

    // Compares one accepted result with the oldest expected one.
    function void check_result(prd_result_t got);
      prd_result_t want;
      if (expected_q.size() == 0) begin
        flag("unexpected result", '0, got);
      end else begin
        want = expected_q.pop_front();
        if (got.address != want.address || got.count != want.count ||
            got.eot != want.eot || got.overflow != want.overflow ||
            got.run_last != want.run_last) begin
          flag("result mismatch", want, got);
        end
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        in_valid_i        = 1'b0;
  logic        in_stall_o;
  logic [31:0] segment_address_i = '0;
  logic [16:0] segment_length_i  = '0;
  logic        final_segment_i   = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i       = 1'b0;
  logic [31:0] entry_address_o;
  logic [15:0] entry_count_o;
  logic        end_of_table_o;
  logic        table_overflow_o;
  logic        run_last_o;

  // Percentages of cycles in which the sender idles or the receiver stalls.
  int unsigned   idle_pct  = 0;
  int unsigned   stall_pct = 0;
  logic          hold_request = 1'b0;
  int unsigned   hold_left = 0;
  int unsigned   quiet_cycles = 0;
  prd_scoreboard sb;

  dma_prd_descriptor_builder dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .segment_address_i (segment_address_i),
    .segment_length_i  (segment_length_i),
    .final_segment_i   (final_segment_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .entry_address_o   (entry_address_o),
    .entry_count_o     (entry_count_o),
    .end_of_table_o    (end_of_table_o),
    .table_overflow_o  (table_overflow_o),
    .run_last_o        (run_last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver side. A hold request from the main sequence starts a long
  // stretch of stall, counted here, so that the block fills up and in turn
  // stalls its input. Otherwise the stall is random at the phase's rate.
  always @(posedge clk_i) begin
    if (hold_request) hold_left = HoldCycles;
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  // All signals change in the nonblocking region, so the values read here
  // are the ones present at the clock edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{entry_address_o, entry_count_o, end_of_table_o,
                        table_overflow_o, run_last_o});
  end

  // Watchdog: ends the run when no request and no result has moved for too
  // long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IdleLimit) begin
        $display("dma_prd_descriptor_builder_test: done, errors");
        $finish;
      end
    end
  end

  // Offers one segment request, after a random idle gap, and waits until the
  // block takes it. The scoreboard learns of the request at the accepting
  // edge, so its state is current when the next request is chosen.
  task automatic send_segment(input logic [31:0] address, input logic [16:0] length,
                              input logic seg_final);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    segment_address_i <= address;
    segment_length_i  <= length;
    final_segment_i   <= seg_final;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_segment(address, length, seg_final);
  endtask

  // Mostly short lengths, with full and nearly full windows, zero lengths and
  // lengths above one window mixed in.
  function automatic logic [16:0] pick_length();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 5) return 17'h0;
    if (r < 8) return 17'($urandom_range(131071, 65537));
    if (r < 18) return 17'(65536 - $urandom_range(3, 0));
    if (r < 35) return 17'($urandom_range(65536, 1));
    return 17'($urandom_range(4096, 1));
  endfunction

  // Random addresses, often just below a 64 KiB boundary or near the top of
  // the address space, so that cuts and wraps happen often.
  function automatic logic [31:0] pick_address();
    logic [31:0] a;
    a = $urandom;
    case ($urandom_range(3, 0))
      0: a[15:0] = 16'(16'hFFFF - $urandom_range(255, 0));
      1: a[31:16] = 16'hFFFF;
      default: ;
    endcase
    return a;
  endfunction

  // One well-formed table of one to six segments. Most segments continue
  // where the previous one ended, so the block has to merge them.
  task automatic send_random_table();
    int unsigned segs;
    logic [31:0] a;
    logic [16:0] l;
    segs = $urandom_range(6, 1);
    a    = pick_address();
    for (int i = 0; i < segs; i++) begin
      l = pick_length();
      send_segment(a, l, i == segs - 1);
      if ($urandom_range(99, 0) < 60) begin
        a = a + ((l > WinBytes) ? 32'(WinBytes) : 32'(l));
      end else begin
        a = pick_address();
      end
    end
  endtask

  // A table that needs more entries than the capacity. Large scattered
  // segments in the upper half of a window are each cut at the boundary, so
  // they fill it quickly. With end_on_overflow set, the last entries are
  // filled with single-entry segments so that the table is filled exactly and
  // the overflowing segment is the final one; otherwise the overflow happens
  // mid-table and a few dropped segments follow up to the final one.
  task automatic send_oversize_table(input bit end_on_overflow);
    logic [31:0] a;
    logic [16:0] l;
    logic        f;
    a = $urandom;
    f = 1'b0;
    while (!sb.dropping && !f) begin
      if (end_on_overflow && sb.entry_total >= Capacity - 2) begin
        a     = $urandom;
        a[15] = 1'b0;
        l     = 17'($urandom_range(256, 1));
        f     = (sb.entry_total == Capacity);
      end else begin
        l     = 17'($urandom_range(65536, 32768));
        a     = $urandom;
        a[15] = 1'b1;
      end
      send_segment(a, l, f);
      a = a + l;
    end
    if (sb.dropping) begin
      repeat ($urandom_range(4, 1)) send_segment($urandom, pick_length(), 1'b0);
      send_segment($urandom, pick_length(), 1'b1);
    end
  endtask

  task automatic drain();
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    sb.clear_run();
    sb.errors = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests: field extremes and the special cases, no idling.
    send_segment(32'h0000_0000, 17'h00001, 1'b1);
    send_segment(32'hFFFF_FFFF, 17'h00001, 1'b1);
    // A full aligned window gives a count of zero; an unaligned one is cut.
    send_segment(32'h1234_0000, 17'h10000, 1'b1);
    send_segment(32'h0001_8000, 17'h10000, 1'b1);
    // Three contiguous segments merge into one entry.
    send_segment(32'h2000_0000, 17'h00100, 1'b0);
    send_segment(32'h2000_0100, 17'h00200, 1'b0);
    send_segment(32'h2000_0300, 17'h00010, 1'b1);
    // A merge that runs into a 64 KiB boundary is cut there.
    send_segment(32'h3000_F000, 17'h00800, 1'b0);
    send_segment(32'h3000_F800, 17'h01000, 1'b1);
    // Zero-length segments: on an empty table, in the middle, and as the
    // final segment that closes the held entry.
    send_segment(32'h8000_0000, 17'h00000, 1'b0);
    send_segment(32'h4000_0000, 17'h00040, 1'b0);
    send_segment(32'h4000_0040, 17'h00000, 1'b0);
    send_segment(32'h5000_0000, 17'h00000, 1'b1);
    // A table without any bytes causes no result.
    send_segment(32'h0000_0000, 17'h00000, 1'b1);
    // Lengths above one window saturate.
    send_segment(32'h6000_0000, 17'h1FFFF, 1'b1);
    send_segment(32'h6000_8000, 17'h10001, 1'b1);
    // Address wrap inside a segment and across a full top window.
    send_segment(32'hFFFF_FFF0, 17'h00100, 1'b1);
    send_segment(32'hFFFF_0000, 17'h10000, 1'b0);
    send_segment(32'h0000_0000, 17'h00010, 1'b1);
    // Scattered segments stay separate entries.
    send_segment(32'h7000_0000, 17'h00010, 1'b0);
    send_segment(32'h7000_1000, 17'h00010, 1'b1);
    in_valid_i <= 1'b0;
    drain();

    // Random phases, each with its own idle and stall pattern. The sender
    // pauses between phases until every expected result has arrived.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      if (phase == 0) begin
        hold_request <= 1'b1;
        @(posedge clk_i);
        hold_request <= 1'b0;
      end
      repeat (6) send_random_table();
      if (phase == 1) send_oversize_table(1'b1);
      if (phase == 2) send_oversize_table(1'b0);
      in_valid_i <= 1'b0;
      drain();
    end

    idle_pct  = 0;
    stall_pct = 0;
    repeat (16) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("dma_prd_descriptor_builder_test: done, clean");
    end else begin
      $display("dma_prd_descriptor_builder_test: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/dpdb_pkg.sv
hdl/dpdb_front.sv
hdl/dpdb_queue.sv
hdl/dpdb_back.sv
hdl/dma_prd_descriptor_builder.sv
test/dma_prd_descriptor_builder_test.sv
